// File: hdl/alm_pkg.sv
package alm_pkg;

  // default geometry
  localparam int unsigned NODES_DEF     = 32;
  localparam int unsigned DATA_BITS_DEF = 32;

  // fixed field widths on the ports
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned INDEX_W = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RM_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RM_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RM_CUR    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// File: hdl/array_linked_list_manager.sv
// Singly linked list of data words kept in NODES node slots (slot 0 means none).
// New nodes come from a LIFO free list, then from a high-water counter of
// never-used slots. One command in, one result out. Rear insert and rear
// remove walk the whole list, remove current walks to the node ahead of the
// current node, search walks until a match or the tail, and clear frees the
// list node by node. A refused command (full, empty list, no cursor) or an
// unused selector ends after decoding. An insert that takes its slot from the
// free list reads the free list first, and a stalled output delays the result.
// A new command can be taken in the same cycle the result is presented. The
// walks are paced by the single read port of the link memory: each step of a
// walk waits for one registered link read. A command is taken only between
// operations; a finished result can wait in the output register while the
// next command is already being worked on.
module array_linked_list_manager
  import alm_pkg::*;
#(
  parameter int unsigned NODES     = NODES_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [2:0]  s_axis_tuser,  // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // node_index[4:0], current_index[9:5],
                                     // current_value[41:10], zero[47:42]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned KW = $clog2(NODES + 1);
  localparam logic [IW-1:0] LastSlot = IW'(NODES - 1);
  localparam logic [KW-1:0] KMax     = KW'(NODES);
  localparam logic [KW-1:0] KLast    = KW'(NODES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RMF, S_RR1, S_WALK, S_RMC_NXT, S_SRCH, S_CLR, S_CLR_W,
    S_ALLOC, S_ALLOC_W, S_INS, S_INS_TAIL, S_FIN, S_OUT
  } state_e;

  state_e               state_q;
  logic [FUNC_W-1:0]    func_q;
  logic [DATA_BITS-1:0] val_q;
  logic [IW-1:0]        head_q, cur_q, hw_q, fh_q;
  logic [IW-1:0]        p_q, pre_q, slot_q;
  logic [KW-1:0]        k_q;
  logic                 rear_q;
  logic [STAT_W-1:0]    status_q;
  logic [IW-1:0]        node_q;
  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [INDEX_W-1:0]   out_node_q, out_cur_q;
  logic [VALUE_W-1:0]   out_val_q;

  // memory ports
  logic                 link_we, free_we, data_we;
  logic [IW-1:0]        link_waddr, free_waddr, data_waddr;
  logic [IW-1:0]        link_wdata, free_wdata;
  logic [IW-1:0]        link_raddr, data_raddr;
  logic [IW-1:0]        link_rdata, free_rdata;
  logic [DATA_BITS-1:0] data_rdata;

  // width adaptation of fixed-width fields
  logic [63:0]             val_ext;
  logic [DATA_BITS-1:0]    val_in;
  logic [DATA_BITS+31:0]   cval_ext;
  logic [IW+INDEX_W-1:0]   node_ext, cur_ext;

  logic full, walk_stop, out_free;

  assign val_ext  = {32'b0, s_axis_tdata};
  assign val_in   = val_ext[DATA_BITS-1:0];
  assign cval_ext = {32'b0, data_rdata};
  assign node_ext = {{INDEX_W{1'b0}}, node_q};
  assign cur_ext  = {{INDEX_W{1'b0}}, cur_q};

  assign full      = (fh_q == '0) && (hw_q >= LastSlot);
  assign walk_stop = (k_q == KMax) || (link_rdata == '0);
  assign out_free  = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'b0, out_val_q, out_cur_q, out_node_q};

  // node storage
  alm_ram #(.DEPTH(NODES), .WIDTH(IW)) u_link (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  alm_ram #(.DEPTH(NODES), .WIDTH(IW)) u_free (
    .clk_i  (clk_i),
    .we_i   (free_we),
    .waddr_i(free_waddr),
    .wdata_i(free_wdata),
    .raddr_i(fh_q),
    .rdata_o(free_rdata)
  );

  alm_ram #(.DEPTH(NODES), .WIDTH(DATA_BITS)) u_data (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(data_waddr),
    .wdata_i(val_q),
    .raddr_i(data_raddr),
    .rdata_o(data_rdata)
  );

  // memory read addresses
  always_comb begin
    link_raddr = head_q;
    data_raddr = cur_q;
    case (state_q)
      S_DEC: begin
        data_raddr = head_q;
      end
      S_RR1, S_WALK: begin
        link_raddr = link_rdata;
      end
      S_SRCH: begin
        link_raddr = link_rdata;
        data_raddr = link_rdata;
      end
      default: begin
      end
    endcase
  end

  // memory writes
  always_comb begin
    link_we    = 1'b0;
    link_waddr = p_q;
    link_wdata = '0;
    free_we    = 1'b0;
    free_waddr = head_q;
    free_wdata = fh_q;
    data_we    = 1'b0;
    data_waddr = slot_q;
    case (state_q)
      S_RMF, S_CLR_W: begin
        free_we = 1'b1;
      end
      S_RR1: begin
        free_we = (link_rdata == '0);
      end
      S_WALK: begin
        if (func_q == FN_RM_REAR && walk_stop) begin
          link_we    = 1'b1;
          link_waddr = pre_q;
          free_we    = 1'b1;
          free_waddr = p_q;
        end
      end
      S_RMC_NXT: begin
        link_we    = 1'b1;
        link_wdata = link_rdata;
        free_we    = 1'b1;
        free_waddr = cur_q;
      end
      S_INS: begin
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = rear_q ? '0 : head_q;
      end
      S_INS_TAIL: begin
        link_we    = 1'b1;
        link_wdata = slot_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      cur_q        <= '0;
      hw_q         <= '0;
      fh_q         <= '0;
      out_valid_q  <= 1'b0;
      func_q       <= '0;
      val_q        <= '0;
      p_q          <= '0;
      pre_q        <= '0;
      slot_q       <= '0;
      k_q          <= '0;
      rear_q       <= 1'b0;
      status_q     <= ST_OK;
      node_q       <= '0;
      out_status_q <= ST_OK;
      out_node_q   <= '0;
      out_cur_q    <= '0;
      out_val_q    <= '0;
    end else begin
      // result taken while no new one is loaded
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func_q   <= s_axis_tuser;
            val_q    <= val_in;
            status_q <= ST_OK;
            node_q   <= '0;
            k_q      <= '0;
            p_q      <= head_q;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          case (func_q)
            FN_INS_FRONT: begin
              rear_q <= 1'b0;
              if (full) begin
                status_q <= ST_FULL;
                state_q  <= S_FIN;
              end else begin
                state_q <= S_ALLOC;
              end
            end
            FN_INS_REAR: begin
              rear_q <= (head_q != '0);
              if (full) begin
                status_q <= ST_FULL;
                state_q  <= S_FIN;
              end else if (head_q == '0) begin
                state_q <= S_ALLOC;
              end else begin
                state_q <= S_WALK;
              end
            end
            FN_RM_FRONT: begin
              if (head_q == '0) begin
                status_q <= ST_EMPTY;
                state_q  <= S_FIN;
              end else begin
                state_q <= S_RMF;
              end
            end
            FN_RM_REAR: begin
              if (head_q == '0) begin
                status_q <= ST_EMPTY;
                state_q  <= S_FIN;
              end else begin
                state_q <= S_RR1;
              end
            end
            FN_RM_CUR: begin
              if (cur_q == '0 || head_q == '0) begin
                status_q <= ST_EMPTY;
                state_q  <= S_FIN;
              end else if (cur_q == head_q) begin
                state_q <= S_RMF;
              end else begin
                state_q <= S_WALK;
              end
            end
            FN_SEARCH: begin
              status_q <= ST_NOTFOUND;
              state_q  <= (head_q == '0) ? S_FIN : S_SRCH;
            end
            FN_CLEAR: begin
              state_q <= S_CLR;
            end
            default: begin
              state_q <= S_FIN;
            end
          endcase
        end
        // unlink the head, link data holds its successor
        S_RMF: begin
          fh_q    <= head_q;
          head_q  <= link_rdata;
          cur_q   <= link_rdata;
          state_q <= S_FIN;
        end
        // rear remove: single node acts as front remove
        S_RR1: begin
          if (link_rdata == '0) begin
            fh_q    <= head_q;
            head_q  <= '0;
            cur_q   <= '0;
            state_q <= S_FIN;
          end else begin
            pre_q   <= head_q;
            p_q     <= link_rdata;
            state_q <= S_WALK;
          end
        end
        // one link per cycle, link data holds the successor of p
        S_WALK: begin
          case (func_q)
            FN_INS_REAR: begin
              if (walk_stop) begin
                state_q <= S_ALLOC;
              end else begin
                p_q <= link_rdata;
                k_q <= k_q + 1'b1;
              end
            end
            FN_RM_REAR: begin
              if (walk_stop) begin
                fh_q    <= p_q;
                cur_q   <= pre_q;
                state_q <= S_FIN;
              end else begin
                pre_q <= p_q;
                p_q   <= link_rdata;
                k_q   <= k_q + 1'b1;
              end
            end
            default: begin
              if (link_rdata == cur_q) begin
                state_q <= S_RMC_NXT;
              end else if (walk_stop) begin
                status_q <= ST_EMPTY;
                state_q  <= S_FIN;
              end else begin
                p_q <= link_rdata;
                k_q <= k_q + 1'b1;
              end
            end
          endcase
        end
        // unlink the current node behind its predecessor
        S_RMC_NXT: begin
          fh_q    <= cur_q;
          cur_q   <= p_q;
          state_q <= S_FIN;
        end
        // compare one node per cycle
        S_SRCH: begin
          if (data_rdata == val_q) begin
            status_q <= ST_OK;
            node_q   <= p_q;
            cur_q    <= p_q;
            state_q  <= S_FIN;
          end else if (link_rdata == '0 || k_q == KLast) begin
            state_q <= S_FIN;
          end else begin
            p_q <= link_rdata;
            k_q <= k_q + 1'b1;
          end
        end
        // clear: free nodes from head to tail
        S_CLR: begin
          if (k_q == KMax || head_q == '0) begin
            head_q  <= '0;
            cur_q   <= '0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_CLR_W;
          end
        end
        S_CLR_W: begin
          fh_q    <= head_q;
          head_q  <= link_rdata;
          k_q     <= k_q + 1'b1;
          state_q <= S_CLR;
        end
        // slot from the free list, else from the high-water mark
        S_ALLOC: begin
          if (fh_q != '0) begin
            slot_q  <= fh_q;
            state_q <= S_ALLOC_W;
          end else begin
            hw_q    <= hw_q + 1'b1;
            slot_q  <= hw_q + 1'b1;
            state_q <= S_INS;
          end
        end
        S_ALLOC_W: begin
          fh_q    <= free_rdata;
          state_q <= S_INS;
        end
        S_INS: begin
          if (!rear_q) begin
            head_q <= slot_q;
          end
          cur_q   <= slot_q;
          node_q  <= slot_q;
          state_q <= rear_q ? S_INS_TAIL : S_FIN;
        end
        S_INS_TAIL: begin
          state_q <= S_FIN;
        end
        // data of the cursor node is read here
        S_FIN: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_node_q   <= node_ext[INDEX_W-1:0];
            out_cur_q    <= cur_ext[INDEX_W-1:0];
            out_val_q    <= (cur_q != '0) ? cval_ext[VALUE_W-1:0] : '0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a command is taken only between operations
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while an operation is running");

  // every freed slot was handed out before
  a_free_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fh_q <= hw_q)
    else $error("free list top above high-water mark");

  // a cursor implies a non-empty list between operations
  a_cursor_on_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && (cur_q != '0) |-> (head_q != '0))
    else $error("cursor set on an empty list");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result overwritten");
`endif

endmodule

// File: hdl/alm_ram.sv
module alm_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
